// ===== sv/fnv_pkg.sv =====
// Shared types, constants and hash step function for the FNV-1 hash block.
`default_nettype none
package fnv_pkg;

    localparam int HASH_W    = 32;
    localparam int BUCKET_W  = 31;
    localparam int BYTE_W    = 8;
    localparam int STEP_CNT_W = $clog2(HASH_W);
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;
    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;

    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(HASH_W - 1);

    localparam logic REG_BUCKET_COUNT = 1'b0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } rem_ctrl_t;

    // The prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 2^0, so the product is a sum of shifts.
    function automatic logic [HASH_W-1:0] fnv_step(
        input logic [HASH_W-1:0] hash,
        input logic [BYTE_W-1:0] data
    );
        logic [HASH_W-1:0] prod;
        prod = (hash << 24) + (hash << 8) + (hash << 7) + (hash << 4) + (hash << 1) + hash;
        return prod ^ {{(HASH_W-BYTE_W){1'b0}}, data};
    endfunction

endpackage
`default_nettype wire

// ===== sv/fnv_rem.sv =====
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none
module fnv_rem
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire fnv_pkg::rem_ctrl_t             ctrl,
    input  wire logic [fnv_pkg::HASH_W-1:0]     dividend,
    input  wire logic [fnv_pkg::BUCKET_W-1:0]   divisor,
    output logic [fnv_pkg::HASH_W-1:0]          remainder
);

    logic [fnv_pkg::BUCKET_W-1:0] rem_reg;
    logic [fnv_pkg::BUCKET_W-1:0] rem_next;
    logic [fnv_pkg::HASH_W-1:0]   dvd_reg;
    logic [fnv_pkg::HASH_W-1:0]   dvd_next;
    logic [fnv_pkg::HASH_W-1:0]   trial;
    logic [fnv_pkg::HASH_W-1:0]   divisor_ext;
    logic [fnv_pkg::HASH_W-1:0]   diff;

    assign trial       = {rem_reg, dvd_reg[fnv_pkg::HASH_W-1]};
    assign divisor_ext = {1'b0, divisor};
    assign diff        = trial - divisor_ext;

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
            dvd_next = dividend;
        end
        else if (ctrl.step)
        begin
            if (trial >= divisor_ext)
            begin
                rem_next = diff[fnv_pkg::BUCKET_W-1:0];
            end
            else
            begin
                rem_next = trial[fnv_pkg::BUCKET_W-1:0];
            end
            dvd_next = {dvd_reg[fnv_pkg::HASH_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            dvd_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
            dvd_reg <= dvd_next;
        end
    end

    assign remainder = {1'b0, rem_reg};

endmodule
`default_nettype wire

// ===== sv/fnv1_hash_with_modulo.sv =====
// Top level of the FNV-1 32-bit hash with bucket reduction and its sequencer.
// A byte that is not the last of its message is folded into the hash, one per cycle while the sequencer is idle.
// A last byte with bucket_count zero gives its result in the cycle after acceptance.
// Otherwise the remainder unit is loaded, ST_REDUCE runs its restoring steps and ST_FINISH
// registers the remainder as the result; the input stalls meanwhile.
// Reset loads the offset basis, clears bucket_count and drops all valid flags.
`default_nettype none
module fnv1_hash_with_modulo
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [fnv_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [fnv_pkg::PDATA_W-1:0]      pwdata,
    output logic [fnv_pkg::PDATA_W-1:0]           prdata,
    output logic                                  pready,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [fnv_pkg::BYTE_W-1:0]       data_byte,
    input  wire logic                             last_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [fnv_pkg::HASH_W-1:0]            hash_value
);

    fnv_pkg::state_t                 state_reg;
    fnv_pkg::state_t                 state_next;
    logic [fnv_pkg::HASH_W-1:0]      hash_reg;
    logic [fnv_pkg::HASH_W-1:0]      hash_next;
    logic [fnv_pkg::BUCKET_W-1:0]    bucket_count_reg;
    logic [fnv_pkg::STEP_CNT_W-1:0]  cnt_reg;
    logic [fnv_pkg::STEP_CNT_W-1:0]  cnt_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [fnv_pkg::HASH_W-1:0]      out_reg;
    logic [fnv_pkg::HASH_W-1:0]      out_next;
    logic [fnv_pkg::HASH_W-1:0]      step_hash;
    logic [fnv_pkg::HASH_W-1:0]      remainder;
    fnv_pkg::rem_ctrl_t              rem_ctrl;
    logic                            in_accept;
    logic                            cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_count_reg <= '0;
        end
        else if (cfg_write && paddr[2] == fnv_pkg::REG_BUCKET_COUNT)
        begin
            bucket_count_reg <= pwdata[fnv_pkg::BUCKET_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == fnv_pkg::REG_BUCKET_COUNT)
        begin
            prdata = {1'b0, bucket_count_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    assign step_hash = fnv_pkg::fnv_step(hash_reg, data_byte);
    assign in_stall  = (state_reg != fnv_pkg::ST_IDLE) | (out_valid_reg & last_byte);
    assign in_accept = in_valid & ~in_stall;

    always_comb
    begin
        state_next     = state_reg;
        hash_next      = hash_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rem_ctrl.load  = 1'b0;
        rem_ctrl.step  = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            fnv_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (!last_byte)
                    begin
                        hash_next = step_hash;
                    end
                    else
                    begin
                        hash_next = fnv_pkg::FNV_BASIS;
                        if (bucket_count_reg == '0)
                        begin
                            out_next       = step_hash;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            rem_ctrl.load = 1'b1;
                            cnt_next      = '0;
                            state_next    = fnv_pkg::ST_REDUCE;
                        end
                    end
                end
            end
            fnv_pkg::ST_REDUCE:
            begin
                rem_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == fnv_pkg::STEP_LAST)
                begin
                    state_next = fnv_pkg::ST_FINISH;
                end
            end
            fnv_pkg::ST_FINISH:
            begin
                out_next       = remainder;
                out_valid_next = 1'b1;
                state_next     = fnv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fnv_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fnv_pkg::ST_IDLE;
            hash_reg      <= fnv_pkg::FNV_BASIS;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    fnv_rem u_rem
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rem_ctrl),
        .dividend  (step_hash),
        .divisor   (bucket_count_reg),
        .remainder (remainder)
    );

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

endmodule
`default_nettype wire

// ===== bench/fnv1_hash_with_modulo_tb.sv =====
// Self-checking testbench for the FNV-1 hash block: directed table, random messages, APB setup.
module fnv1_hash_with_modulo_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS = 105;
    localparam int PHASE_COUNT = 6;
    localparam int DIR_ROWS = 25;
    localparam logic [fnv_pkg::PADDR_W-1:0] BUCKETS_ADDR =
        fnv_pkg::PADDR_W'(4 * int'(fnv_pkg::REG_BUCKET_COUNT));

    typedef enum logic {
        ROW_BYTE,
        ROW_BUCKETS
    } row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic [fnv_pkg::PDATA_W-1:0]  value;
        logic                         last;
        logic                         pinned;
        logic [fnv_pkg::HASH_W-1:0]   pin_hash;
    } row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [fnv_pkg::PADDR_W-1:0]   paddr = '0;
    logic [fnv_pkg::PDATA_W-1:0]   pwdata = '0;
    logic [fnv_pkg::PDATA_W-1:0]   prdata;
    logic                          pready;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [fnv_pkg::BYTE_W-1:0]    data_byte = '0;
    logic                          last_byte = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [fnv_pkg::HASH_W-1:0]    hash_value;

    logic [fnv_pkg::HASH_W-1:0]    model_hash = fnv_pkg::FNV_BASIS;
    logic [fnv_pkg::BUCKET_W-1:0]  model_buckets = '0;
    logic [fnv_pkg::HASH_W-1:0]    hash_expect_q [$];
    logic                          item_pinned = 1'b0;
    logic [fnv_pkg::HASH_W-1:0]    item_pin_hash = '0;
    int                            send_idle_pct = 0;
    int                            stall_pct = 0;
    int                            holdoff_left = 0;
    int                            mismatch_count = 0;
    int                            cycle_count = 0;
    int                            items_sent = 0;
    row_t                          dir_rows [0:DIR_ROWS-1];

    fnv1_hash_with_modulo dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hash_value (hash_value)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [fnv_pkg::HASH_W-1:0] got,
                                   input logic [fnv_pkg::HASH_W-1:0] want);
        mismatch_count++;
        $display("mismatch (%s): got %h, expected %h, cycle %0d", what, got, want,
                 cycle_count);
    endtask

    always @(posedge clk)
    begin
        logic [fnv_pkg::HASH_W-1:0] folded;
        if (rst_n && in_valid && !in_stall)
        begin
            folded = (model_hash * fnv_pkg::FNV_PRIME)
                     ^ {{(fnv_pkg::HASH_W-fnv_pkg::BYTE_W){1'b0}}, data_byte};
            if (last_byte)
            begin
                if (model_buckets != '0)
                begin
                    folded = folded % {1'b0, model_buckets};
                end
                hash_expect_q.push_back(item_pinned ? item_pin_hash : folded);
                model_hash = fnv_pkg::FNV_BASIS;
            end
            else
            begin
                model_hash = folded;
            end
        end
    end

    always @(posedge clk)
    begin
        logic [fnv_pkg::HASH_W-1:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (hash_expect_q.size() == 0)
            begin
                report_mismatch("unexpected transaction", hash_value, '0);
            end
            else
            begin
                want = hash_expect_q.pop_front();
                if (hash_value !== want)
                begin
                    report_mismatch("hash_value", hash_value, want);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (holdoff_left > 0)
        begin
            out_stall <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_byte(input logic [fnv_pkg::BYTE_W-1:0] b, input logic l,
                             input logic pin, input logic [fnv_pkg::HASH_W-1:0] pin_hash);
        @(negedge clk);
        while (holdoff_left == 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            data_byte <= fnv_pkg::BYTE_W'($urandom);
            last_byte <= 1'($urandom);
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        item_pinned = pin;
        item_pin_hash = pin_hash;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (hash_expect_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_buckets(input logic [fnv_pkg::PDATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= BUCKETS_ADDR;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        model_buckets = value[fnv_pkg::BUCKET_W-1:0];
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {1'b0, model_buckets})
        begin
            report_mismatch("bucket_count readback", prdata, {1'b0, model_buckets});
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_message();
        int len;
        int k;
        logic [fnv_pkg::BYTE_W-1:0] b;
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        for (k = 0; k < len; k++)
        begin
            case ($urandom_range(7))
                0:       b = 8'h00;
                1:       b = 8'hff;
                default: b = fnv_pkg::BYTE_W'($urandom);
            endcase
            send_byte(b, k == len - 1, 1'b0, '0);
            items_sent++;
        end
    endtask

    initial
    begin
        int phase;
        int goal;
        logic [fnv_pkg::PDATA_W-1:0] buckets;
        dir_rows = '{
            '{ROW_BYTE,    32'h00,       1'b1, 1'b1, 32'h050c5d1f},
            '{ROW_BYTE,    32'hff,       1'b1, 1'b1, 32'h050c5de0},
            '{ROW_BYTE,    32'h61,       1'b1, 1'b1, 32'h050c5d7e},
            '{ROW_BYTE,    32'h61,       1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h62,       1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h63,       1'b1, 1'b0, 32'h0},
            '{ROW_BUCKETS, 32'h1,        1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h5a,       1'b1, 1'b1, 32'h0},
            '{ROW_BYTE,    32'hff,       1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h00,       1'b1, 1'b1, 32'h0},
            '{ROW_BUCKETS, 32'h7fffffff, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h00,       1'b1, 1'b1, 32'h050c5d1f},
            '{ROW_BYTE,    32'h80,       1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h7f,       1'b0, 1'b0, 32'h0},
            '{ROW_BUCKETS, 32'hffffffff, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h33,       1'b1, 1'b0, 32'h0},
            '{ROW_BUCKETS, 32'h2,        1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h00,       1'b1, 1'b1, 32'h1},
            '{ROW_BYTE,    32'hff,       1'b1, 1'b1, 32'h0},
            '{ROW_BYTE,    32'h10,       1'b0, 1'b0, 32'h0},
            '{ROW_BUCKETS, 32'h80000000, 1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h20,       1'b1, 1'b0, 32'h0},
            '{ROW_BUCKETS, 32'd1000,     1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'haa,       1'b0, 1'b0, 32'h0},
            '{ROW_BYTE,    32'h55,       1'b1, 1'b0, 32'h0}
        };
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_BUCKETS)
            begin
                wait_idle();
                write_buckets(dir_rows[i].value);
            end
            else
            begin
                send_byte(dir_rows[i].value[fnv_pkg::BYTE_W-1:0], dir_rows[i].last,
                          dir_rows[i].pinned, dir_rows[i].pin_hash);
            end
        end

        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            wait_idle();
            case (phase)
                0:       buckets = '0;
                1:       buckets = $urandom_range(16, 1);
                2:       buckets = 32'h7fffffff;
                3:       buckets = $urandom;
                4:       buckets = $urandom_range(1000, 1);
                default: buckets = 32'h80000000 | $urandom_range(255, 1);
            endcase
            write_buckets(buckets);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct = 6;
                end
            endcase
            if (phase == PHASE_COUNT - 1)
            begin
                holdoff_left = 400;
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
            begin
                send_message();
            end
        end

        wait_idle();
        if (mismatch_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
